### src/ffha_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_pkg
// Constants, types and codes shared by the first-fit heap allocator modules.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int HEAP_BYTES      = 4096;
  localparam int ALIGN_BYTES     = 8;
  localparam int MIN_CHUNK_BYTES = 16;
  localparam int HEADER_BYTES    = 16;

  // Smallest payload that an allocation is raised to.
  localparam int MIN_PAYLOAD = (MIN_CHUNK_BYTES > HEADER_BYTES) ?
                               (MIN_CHUNK_BYTES - HEADER_BYTES) : 0;

  localparam int SZ_W     = $clog2(HEAP_BYTES);        // payload size / offset
  localparam int NEED_W   = SZ_W + 1;                  // rounded request
  localparam int P_W      = SZ_W + 2;                  // walk pointer
  localparam int ALIGN_SH = $clog2(ALIGN_BYTES);
  localparam int DEPTH    = HEAP_BYTES / ALIGN_BYTES;
  localparam int AW       = $clog2(DEPTH);
  localparam int CNT_W    = 9;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_LEAK  = 2'd2,
    REQ_RSVD  = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_NOMEM    = 3'd2,
    ST_BADPTR   = 3'd3,
    ST_MISALIGN = 3'd4,
    ST_DBLFREE  = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_READ_P,
    OP_STEP,
    OP_WR_P_ALLOC,
    OP_WR_Q,
    OP_HOLD_H,
    OP_READ_NX,
    OP_MERGE_NX,
    OP_WR_H,
    OP_WR_PREV
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_RD,
    S_EV,
    S_WRQ,
    S_RDN,
    S_EVN,
    S_WRH,
    S_WRPV
  } state_e;

  typedef struct packed {
    logic            used;
    logic [SZ_W-1:0] size;
  } entry_t;

  typedef struct packed {
    dp_op_e  op;
    logic    done;
    status_e status;
  } cmd_t;

  typedef struct packed {
    req_type_e rtype;
    logic      zero_size;
    logic      is_null;
    logic      off_range;
    logic      misaligned;
    logic      off_low;
    logic      p_end;
    logic      cur_used;
    logic      fit;
    logic      split;
    logic      p_lt_h;
    logic      p_eq_h;
    logic      next_in;
    logic      prev_merge;
  } sts_t;

endpackage
`default_nettype wire

### src/ffha_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_dp
// Datapath: header memory, walk pointer, request registers and result words.
// ----------------------------------------------------------------------------
module ffha_dp import ffha_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cmd_t            cmd_i,
  output sts_t                 sts_o,
  input  wire logic [1:0]      req_type_i,
  input  wire logic [11:0]     req_bytes_i,
  input  wire logic [11:0]     free_offset_i,
  input  wire logic            free_is_null_i,
  output logic                 valid_o,
  output logic [2:0]           status_o,
  output logic [11:0]          payload_offset_o,
  output logic [8:0]           leak_count_o,
  output logic [11:0]          leak_total_o
);

  logic [1:0]        type_q;
  logic              null_q;
  logic [11:0]       bytes_q;
  logic [11:0]       off_q;
  logic [NEED_W-1:0] need_q;
  logic [P_W-1:0]    p_q, h_q, prev_q;
  logic              prev_vld_q, prev_used_q;
  logic [SZ_W-1:0]   prev_size_q, rem_q, hsize_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [11:0]       sum_q;
  entry_t            hdr0_q;
  logic [$bits(entry_t)-1:0] rd_q;
  logic              rd_is0_q;
  logic [$bits(entry_t)-1:0] mem_q [DEPTH];

  entry_t            cur;
  logic [NEED_W-1:0] need_raw, need_d;
  logic [P_W-1:0]    next_p, q_addr, nx_addr, rd_addr, wr_addr;
  logic              re, we;
  entry_t            wdata;

  assign cur = rd_is0_q ? hdr0_q : entry_t'(rd_q);

  assign need_raw = (NEED_W'(req_bytes_i) + NEED_W'(ALIGN_BYTES - 1))
                    & ~NEED_W'(ALIGN_BYTES - 1);
  assign need_d   = (need_raw < NEED_W'(MIN_PAYLOAD)) ? NEED_W'(MIN_PAYLOAD) : need_raw;

  assign next_p  = p_q + P_W'(HEADER_BYTES) + P_W'(cur.size);
  assign q_addr  = p_q + P_W'(HEADER_BYTES) + P_W'(need_q);
  assign nx_addr = h_q + P_W'(HEADER_BYTES) + P_W'(hsize_q);

  always_comb begin
    sts_o.rtype      = req_type_e'(type_q);
    sts_o.zero_size  = (bytes_q == '0);
    sts_o.is_null    = null_q;
    sts_o.off_range  = ({1'b0, off_q} >= 13'(HEAP_BYTES));
    sts_o.misaligned = (off_q[ALIGN_SH-1:0] != '0);
    sts_o.off_low    = (off_q < 12'(HEADER_BYTES));
    sts_o.p_end      = (p_q >= P_W'(HEAP_BYTES));
    sts_o.cur_used   = cur.used;
    sts_o.fit        = !cur.used && (NEED_W'(cur.size) >= need_q);
    sts_o.split      = (P_W'(cur.size) >= P_W'(need_q) + P_W'(HEADER_BYTES + MIN_CHUNK_BYTES))
                       && (q_addr < P_W'(HEAP_BYTES));
    sts_o.p_lt_h     = (p_q < h_q);
    sts_o.p_eq_h     = (p_q == h_q);
    sts_o.next_in    = (next_p < P_W'(HEAP_BYTES));
    sts_o.prev_merge = prev_vld_q && !prev_used_q;
  end

  // Read and write port selection.
  always_comb begin
    re      = 1'b0;
    rd_addr = p_q;
    we      = 1'b0;
    wr_addr = p_q;
    wdata   = cur;
    unique case (cmd_i.op)
      OP_READ_P: re = 1'b1;
      OP_READ_NX: begin
        re      = 1'b1;
        rd_addr = nx_addr;
      end
      OP_WR_P_ALLOC: begin
        we         = 1'b1;
        wdata.used = 1'b1;
        wdata.size = sts_o.split ? SZ_W'(need_q) : cur.size;
      end
      OP_WR_Q: begin
        we      = 1'b1;
        wr_addr = q_addr;
        wdata   = '{used: 1'b0, size: rem_q};
      end
      OP_WR_H: begin
        we      = 1'b1;
        wr_addr = h_q;
        wdata   = '{used: 1'b0, size: hsize_q};
      end
      OP_WR_PREV: begin
        we      = 1'b1;
        wr_addr = prev_q;
        wdata   = '{used: 1'b0,
                    size: SZ_W'(prev_size_q + SZ_W'(HEADER_BYTES) + hsize_q)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_addr[ALIGN_SH +: AW]] <= wdata;
    end
    if (re) begin
      rd_q <= mem_q[rd_addr[ALIGN_SH +: AW]];
    end
  end

  // The first chunk header lives in flops so that reset leaves a valid heap.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr0_q   <= '{used: 1'b0, size: SZ_W'(HEAP_BYTES - HEADER_BYTES)};
      rd_is0_q <= 1'b0;
      valid_o  <= 1'b0;
    end else begin
      if (we && (wr_addr[ALIGN_SH +: AW] == '0)) begin
        hdr0_q <= wdata;
      end
      if (re) begin
        rd_is0_q <= (rd_addr[ALIGN_SH +: AW] == '0);
      end
      valid_o <= cmd_i.done;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        type_q     <= req_type_i;
        null_q     <= free_is_null_i;
        bytes_q    <= req_bytes_i;
        off_q      <= free_offset_i;
        need_q     <= need_d;
        h_q        <= P_W'(free_offset_i) - P_W'(HEADER_BYTES);
        p_q        <= '0;
        prev_vld_q <= 1'b0;
        cnt_q      <= '0;
        sum_q      <= '0;
      end
      OP_STEP: begin
        prev_q      <= p_q;
        prev_vld_q  <= 1'b1;
        prev_size_q <= cur.size;
        prev_used_q <= cur.used;
        p_q         <= next_p;
        if (cur.used) begin
          cnt_q <= cnt_q + CNT_W'(1);
          sum_q <= sum_q + 12'(cur.size);
        end
      end
      OP_WR_P_ALLOC: rem_q <= SZ_W'(P_W'(cur.size) - P_W'(HEADER_BYTES) - P_W'(need_q));
      OP_HOLD_H: hsize_q <= cur.size;
      OP_MERGE_NX: begin
        if (!cur.used) begin
          hsize_q <= SZ_W'(hsize_q + SZ_W'(HEADER_BYTES) + cur.size);
        end
      end
      default: ;
    endcase
  end

  // Result word; fields that do not apply to the request read as zero.
  always_ff @(posedge clk_i) begin
    if (cmd_i.done) begin
      status_o         <= cmd_i.status;
      payload_offset_o <= ((type_q == REQ_ALLOC) && (cmd_i.status == ST_OK)) ?
                          12'(p_q + P_W'(HEADER_BYTES)) : 12'd0;
      leak_count_o     <= (type_q == REQ_LEAK) ? cnt_q : '0;
      leak_total_o     <= (type_q == REQ_LEAK) ? sum_q : 12'd0;
    end
  end

endmodule
`default_nettype wire

### src/ffha_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_ctrl
// Controller: sequences the header walk, split, merge and result for a word.
// ----------------------------------------------------------------------------
module ffha_ctrl import ffha_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d       = state_q;
    cmd_o.op      = OP_NONE;
    cmd_o.done    = 1'b0;
    cmd_o.status  = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DEC;
        end
      end
      S_DEC: begin
        state_d = S_RD;
        case (sts_i.rtype)
          REQ_ALLOC: begin
            if (sts_i.zero_size) begin
              cmd_o.done   = 1'b1;
              cmd_o.status = ST_ZERO;
              state_d      = S_IDLE;
            end
          end
          REQ_FREE: begin
            if (sts_i.is_null || sts_i.off_range || sts_i.misaligned || sts_i.off_low) begin
              cmd_o.done = 1'b1;
              state_d    = S_IDLE;
              if (sts_i.is_null) cmd_o.status = ST_OK;
              else if (sts_i.off_range) cmd_o.status = ST_BADPTR;
              else if (sts_i.misaligned) cmd_o.status = ST_MISALIGN;
              else cmd_o.status = ST_BADPTR;
            end
          end
          REQ_LEAK: ;
          default: begin
            cmd_o.done = 1'b1;
            state_d    = S_IDLE;
          end
        endcase
      end
      S_RD: begin
        cmd_o.op = OP_READ_P;
        state_d  = S_EV;
      end
      S_EV: begin
        case (sts_i.rtype)
          REQ_ALLOC: begin
            if (sts_i.p_end) begin
              cmd_o.done   = 1'b1;
              cmd_o.status = ST_NOMEM;
              state_d      = S_IDLE;
            end else if (sts_i.fit) begin
              cmd_o.op = OP_WR_P_ALLOC;
              if (sts_i.split) begin
                state_d = S_WRQ;
              end else begin
                cmd_o.done = 1'b1;
                state_d    = S_IDLE;
              end
            end else begin
              cmd_o.op = OP_STEP;
              state_d  = S_RD;
            end
          end
          REQ_FREE: begin
            if (!sts_i.p_end && sts_i.p_lt_h) begin
              cmd_o.op = OP_STEP;
              state_d  = S_RD;
            end else if (!sts_i.p_end && sts_i.p_eq_h) begin
              if (!sts_i.cur_used) begin
                cmd_o.done   = 1'b1;
                cmd_o.status = ST_DBLFREE;
                state_d      = S_IDLE;
              end else begin
                cmd_o.op = OP_HOLD_H;
                state_d  = sts_i.next_in ? S_RDN : S_WRH;
              end
            end else begin
              cmd_o.done   = 1'b1;
              cmd_o.status = ST_BADPTR;
              state_d      = S_IDLE;
            end
          end
          default: begin
            if (sts_i.p_end) begin
              cmd_o.done = 1'b1;
              state_d    = S_IDLE;
            end else begin
              cmd_o.op = OP_STEP;
              state_d  = S_RD;
            end
          end
        endcase
      end
      S_WRQ: begin
        cmd_o.op   = OP_WR_Q;
        cmd_o.done = 1'b1;
        state_d    = S_IDLE;
      end
      S_RDN: begin
        cmd_o.op = OP_READ_NX;
        state_d  = S_EVN;
      end
      S_EVN: begin
        cmd_o.op = OP_MERGE_NX;
        state_d  = S_WRH;
      end
      S_WRH: begin
        cmd_o.op = OP_WR_H;
        if (sts_i.prev_merge) begin
          state_d = S_WRPV;
        end else begin
          cmd_o.done = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_WRPV: begin
        cmd_o.op   = OP_WR_PREV;
        cmd_o.done = 1'b1;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### src/first_fit_heap_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over a 4096-byte heap kept as a list of chunk headers.
// ----------------------------------------------------------------------------
// A request word is taken at a rising edge where start is high and busy is
// low. Busy then stays high through the decode state, a read and an evaluate
// state for every chunk header read, a further write state when an allocate
// splits a chunk, and the states in which a free reads the next header,
// merges and writes back. The result word is registered and comes in the
// first cycle in which busy is low again, with valid_o high for exactly one
// cycle, and the receiver cannot stall it. Every request that passes decode
// walks the chunk headers from offset zero through the header memory; a
// request rejected at decode finishes in the decode state. The longest request
// is a leak query over the fullest list of 170 chunks; it reads 171 headers,
// counting the read at the heap end. No clearing pass is needed after reset.
module first_fit_heap_allocator import ffha_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [11:0] req_bytes_i,
  input  wire logic [11:0] free_offset_i,
  input  wire logic        free_is_null_i,
  output logic             valid_o,
  output logic [2:0]       status_o,
  output logic [11:0]      payload_offset_o,
  output logic [8:0]       leak_count_o,
  output logic [11:0]      leak_total_o
);

  cmd_t cmd;
  sts_t sts;

  ffha_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  ffha_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .req_type_i       (req_type_i),
    .req_bytes_i      (req_bytes_i),
    .free_offset_i    (free_offset_i),
    .free_is_null_i   (free_is_null_i),
    .valid_o          (valid_o),
    .status_o         (status_o),
    .payload_offset_o (payload_offset_o),
    .leak_count_o     (leak_count_o),
    .leak_total_o     (leak_total_o)
  );

endmodule
`default_nettype wire

### src/ffha_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffha_checker import ffha_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        valid_o,
  input wire logic [2:0]  status_o,
  input wire logic [11:0] payload_offset_o
);

  // An accepted word keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accepted word");

  // Results never come in back-to-back cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("back-to-back results");

  // A result always follows a busy cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy))
    else $error("result without work");

  // A failed request never reports an allocated offset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (status_o != ST_OK) |-> (payload_offset_o == 12'd0))
    else $error("offset on failed request");

  // Status codes stay within the defined set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (status_o == ST_OK) || (status_o == ST_ZERO) || (status_o == ST_NOMEM) ||
                (status_o == ST_BADPTR) || (status_o == ST_MISALIGN) ||
                (status_o == ST_DBLFREE))
    else $error("undefined status code");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .valid_o          (valid_o),
  .status_o         (status_o),
  .payload_offset_o (payload_offset_o)
);
`default_nettype wire

### test/ffha_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ffha_tb_checker
// Watches the request and result words of the first-fit heap allocator, keeps
// its own picture of the chunk list, and compares every result word with the
// one the picture predicts.
// ----------------------------------------------------------------------------
module ffha_tb_checker import ffha_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [11:0] req_bytes_i,
  input  wire logic [11:0] free_offset_i,
  input  wire logic        free_is_null_i,
  input  wire logic        valid_o,
  input  wire logic [2:0]  status_o,
  input  wire logic [11:0] payload_offset_o,
  input  wire logic [8:0]  leak_count_o,
  input  wire logic [11:0] leak_total_o,
  output int               fail_count,
  output int               pending_count
);

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] offset;
    logic [8:0]  count;
    logic [11:0] bytes;
  } outcome_t;

  // Chunk sizes and allocated flags, indexed by chunk start byte offset.
  int unsigned chunk_size [HEAP_BYTES];
  bit          chunk_used [HEAP_BYTES];
  outcome_t    expected_q [$];

  function automatic int unsigned after(int unsigned p);
    return p + HEADER_BYTES + chunk_size[p];
  endfunction

  function automatic outcome_t allocate(int unsigned req);
    outcome_t r;
    int unsigned need, p, guard, q;
    r = '0;
    if (req == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    need = ((req + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    if (need < MIN_PAYLOAD) need = MIN_PAYLOAD;
    p = 0;
    guard = 0;
    while (p < HEAP_BYTES && guard < HEAP_BYTES) begin
      if (!chunk_used[p] && chunk_size[p] >= need) break;
      p = after(p);
      guard++;
    end
    if (p >= HEAP_BYTES || guard >= HEAP_BYTES) begin
      r.status = ST_NOMEM;
      return r;
    end
    if (chunk_size[p] >= need + HEADER_BYTES + MIN_CHUNK_BYTES) begin
      q = p + HEADER_BYTES + need;
      if (q < HEAP_BYTES) begin
        chunk_size[q] = chunk_size[p] - HEADER_BYTES - need;
        chunk_used[q] = 0;
        chunk_size[p] = need;
      end
    end
    chunk_used[p] = 1;
    r.status = ST_OK;
    r.offset = 12'(p + HEADER_BYTES);
    return r;
  endfunction

  function automatic outcome_t release_chunk(int unsigned off);
    outcome_t r;
    int unsigned h, p, pr, guard, nx;
    r = '0;
    if (off >= HEAP_BYTES) begin
      r.status = ST_BADPTR;
      return r;
    end
    if (off % ALIGN_BYTES != 0) begin
      r.status = ST_MISALIGN;
      return r;
    end
    if (off < HEADER_BYTES) begin
      r.status = ST_BADPTR;
      return r;
    end
    h = off - HEADER_BYTES;
    p = 0;
    pr = HEAP_BYTES;
    guard = 0;
    while (p < h && p < HEAP_BYTES && guard < HEAP_BYTES) begin
      pr = p;
      p = after(p);
      guard++;
    end
    if (!(p == h && p < HEAP_BYTES)) begin
      r.status = ST_BADPTR;
      return r;
    end
    if (!chunk_used[h]) begin
      r.status = ST_DBLFREE;
      return r;
    end
    chunk_used[h] = 0;
    nx = after(h);
    if (nx < HEAP_BYTES && !chunk_used[nx])
      chunk_size[h] += HEADER_BYTES + chunk_size[nx];
    if (pr < HEAP_BYTES && !chunk_used[pr])
      chunk_size[pr] += HEADER_BYTES + chunk_size[h];
    r.status = ST_OK;
    return r;
  endfunction

  function automatic outcome_t survey();
    outcome_t r;
    int unsigned p, guard, cnt, total;
    r = '0;
    p = 0;
    guard = 0;
    cnt = 0;
    total = 0;
    while (p < HEAP_BYTES && guard < HEAP_BYTES) begin
      if (chunk_used[p]) begin
        cnt++;
        total += chunk_size[p];
      end
      p = after(p);
      guard++;
    end
    r.status = ST_OK;
    r.count = 9'(cnt);
    r.bytes = 12'(total);
    return r;
  endfunction

  function automatic outcome_t predict(logic [1:0] kind, logic [11:0] nbytes,
                                       logic [11:0] off, logic is_null);
    outcome_t r;
    r = '0;
    case (kind)
      REQ_ALLOC: r = allocate(nbytes);
      REQ_FREE:  if (!is_null) r = release_chunk(off);
      REQ_LEAK:  r = survey();
      default:   r = '0;
    endcase
    return r;
  endfunction

  assign pending_count = expected_q.size();

  initial begin
    for (int i = 0; i < HEAP_BYTES; i++) begin
      chunk_size[i] = 0;
      chunk_used[i] = 0;
    end
    chunk_size[0] = HEAP_BYTES - HEADER_BYTES;
    fail_count = 0;
  end

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni) begin
      // The result of a word never comes in the cycle in which it is taken, so
      // check first and then predict.
      if (valid_o) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result word status=%0d", $time, status_o);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (status_o !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
            fail_count++;
          end
          if (payload_offset_o !== want.offset) begin
            $display("%0t: payload_offset expected %0d actual %0d", $time, want.offset,
                     payload_offset_o);
            fail_count++;
          end
          if (leak_count_o !== want.count) begin
            $display("%0t: leak_count expected %0d actual %0d", $time, want.count,
                     leak_count_o);
            fail_count++;
          end
          if (leak_total_o !== want.bytes) begin
            $display("%0t: leak_total expected %0d actual %0d", $time, want.bytes,
                     leak_total_o);
            fail_count++;
          end
        end
      end
      if (start && !busy)
        expected_q.push_back(predict(req_type_i, req_bytes_i, free_offset_i, free_is_null_i));
    end
  end

endmodule

### test/tb_first_fit_heap_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator
// Drives directed and random allocate, free, leak and reserved requests into
// the allocator in bursts; the checker beside it predicts and compares results.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic [1:0]  req_type_i = REQ_LEAK;
  logic [11:0] req_bytes_i = '0;
  logic [11:0] free_offset_i = '0;
  logic        free_is_null_i = 0;
  logic        busy, valid_o;
  logic [2:0]  status_o;
  logic [11:0] payload_offset_o, leak_total_o;
  logic [8:0]  leak_count_o;
  int          fail_count, pending_count;
  int          cycles = 0;

  // Offsets handed out by the allocator and not yet freed by the stimulus.
  logic [11:0] live_q [$];
  int          burst_left = 0;

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  first_fit_heap_allocator dut (.*);

  ffha_tb_checker checker_i (.*);

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Collect granted offsets so later frees hit real chunks.
  always @(posedge clk_i)
    if (valid_o && status_o == ST_OK && payload_offset_o != 0)
      live_q.push_back(payload_offset_o);

  task automatic issue(logic [1:0] kind, logic [11:0] nbytes, logic [11:0] off,
                       logic is_null);
    // Random gap between bursts.
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      repeat ($urandom_range(0, 1) ? $urandom_range(1, 20) : 0) @(posedge clk_i);
    end
    burst_left--;
    start <= 1;
    req_type_i <= kind;
    req_bytes_i <= nbytes;
    free_offset_i <= off;
    free_is_null_i <= is_null;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    start <= 0;
    // The block is busy in this cycle, so no word is lost here.
    @(posedge clk_i);
  endtask

  task automatic free_live(bit is_random);
    int k;
    logic [11:0] off;
    if (live_q.size() == 0) begin
      issue(REQ_FREE, 12'($urandom), 12'($urandom), 0);
      return;
    end
    k = is_random ? $urandom_range(0, live_q.size() - 1) : 0;
    off = live_q[k];
    live_q.delete(k);
    issue(REQ_FREE, 12'($urandom), off, 0);
  endtask

  initial begin
    int r;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed part.
    issue(REQ_ALLOC, 12'd0, 12'd0, 0);          // zero size
    issue(REQ_ALLOC, 12'd4095, 12'hFFF, 1);     // larger than the heap payload
    issue(REQ_ALLOC, 12'd1, 12'd0, 0);
    issue(REQ_ALLOC, 12'd8, 12'd0, 0);
    issue(REQ_ALLOC, 12'd100, 12'd0, 0);
    issue(REQ_LEAK, 12'd0, 12'd0, 0);
    issue(REQ_FREE, 12'd0, 12'd0, 1);           // null pointer
    issue(REQ_FREE, 12'd0, 12'd4095, 0);        // misaligned
    issue(REQ_FREE, 12'd0, 12'd8, 0);           // below header
    issue(REQ_FREE, 12'd0, 12'd4088, 0);        // not a chunk start
    issue(REQ_FREE, 12'd0, 12'd40, 0);          // middle chunk
    issue(REQ_FREE, 12'd0, 12'd40, 0);          // double free
    issue(REQ_RSVD, 12'hFFF, 12'hFFF, 1);       // unknown request
    issue(REQ_FREE, 12'd0, 12'd16, 0);          // merges with next
    issue(REQ_FREE, 12'd0, 12'd64, 0);          // merges with previous
    issue(REQ_ALLOC, 12'd4080, 12'd0, 0);       // whole heap
    issue(REQ_LEAK, 12'd0, 12'd0, 0);
    issue(REQ_FREE, 12'd0, 12'd16, 0);
    live_q.delete();
    issue(REQ_ALLOC, 12'd4064, 12'd0, 0);       // no split left over
    issue(REQ_LEAK, 12'd0, 12'd0, 0);
    wait (pending_count == 0);
    live_q.delete();
    issue(REQ_FREE, 12'd0, 12'd16, 0);

    // Random part: mostly well-formed allocate and free traffic.
    for (int i = 0; i < 750; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45)
        issue(REQ_ALLOC, ($urandom_range(0, 9) == 0) ? 12'($urandom)
                                                     : 12'($urandom_range(0, 96)),
              12'($urandom), 1'($urandom));
      else if (r < 80) begin
        // Let outstanding results land so the list of live chunks is current.
        wait (pending_count == 0);
        @(posedge clk_i);
        free_live($urandom_range(0, 1));
      end else if (r < 88)
        issue(REQ_LEAK, 12'($urandom), 12'($urandom), 1'($urandom));
      else if (r < 97)
        issue(REQ_FREE, 12'($urandom), 12'($urandom), 1'($urandom));
      else
        issue(REQ_RSVD, 12'($urandom), 12'($urandom), 1'($urandom));
    end

    wait (pending_count == 0);
    repeat (600) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

### files.f
src/ffha_pkg.sv
src/ffha_dp.sv
src/ffha_ctrl.sv
src/first_fit_heap_allocator.sv
src/ffha_checker.sv
test/ffha_checker.sv
test/tb_first_fit_heap_allocator.sv
